// ===== hw/rtl/ddo_pkg.sv =====
// Shared types, operation codes and constants of the differential drive odometry block.
// Used by ddo_ctrl, ddo_dp and differential_drive_odometry; depends on nothing.
`default_nettype none
package ddo_pkg;

    localparam int DIV_W  = 93;
    localparam int DEN_W  = 53;
    localparam int QUO_W  = 46;
    localparam int ACC_W  = 48;
    localparam int COR_W  = 33;
    localparam int CNT_W  = 7;

    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
    localparam logic signed [COR_W-1:0] CORDIC_X0 = 33'sd652032874;
    localparam logic [47:0] TRAVEL_MAX = 48'h7FFF_FFFF_FFFF;

    localparam logic [2:0] REG_LEFT_PPR    = 3'd0;
    localparam logic [2:0] REG_RIGHT_PPR   = 3'd1;
    localparam logic [2:0] REG_LEFT_RADIUS = 3'd2;
    localparam logic [2:0] REG_RIGHT_RADIUS = 3'd3;
    localparam logic [2:0] REG_WHEEL_BASE  = 3'd4;

    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_CAPTURE  = 5'd1;
    localparam logic [4:0] OP_LOAD     = 5'd2;
    localparam logic [4:0] OP_W_MUL    = 5'd3;
    localparam logic [4:0] OP_W_DIVLD  = 5'd4;
    localparam logic [4:0] OP_DIV_STEP = 5'd5;
    localparam logic [4:0] OP_W_MULHI  = 5'd6;
    localparam logic [4:0] OP_W_MULLO  = 5'd7;
    localparam logic [4:0] OP_W_FIN    = 5'd8;
    localparam logic [4:0] OP_BASE_MUL = 5'd9;
    localparam logic [4:0] OP_T_DIVLD  = 5'd10;
    localparam logic [4:0] OP_T_FIN    = 5'd11;
    localparam logic [4:0] OP_COR_LD   = 5'd12;
    localparam logic [4:0] OP_COR_STEP = 5'd13;
    localparam logic [4:0] OP_COR_FIN  = 5'd14;
    localparam logic [4:0] OP_S_MULHI  = 5'd15;
    localparam logic [4:0] OP_S_MULLO  = 5'd16;
    localparam logic [4:0] OP_S_FIN    = 5'd17;
    localparam logic [4:0] OP_D_MULX   = 5'd18;
    localparam logic [4:0] OP_D_MULY   = 5'd19;
    localparam logic [4:0] OP_SQ_LD    = 5'd20;
    localparam logic [4:0] OP_SQ_STEP  = 5'd21;
    localparam logic [4:0] OP_OUT      = 5'd22;

    typedef struct packed {
        logic [4:0]       op;
        logic             sel;
        logic [CNT_W-1:0] idx;
    } ddo_cmd_t;

    typedef struct packed {
        logic action;
        logic out_free;
    } ddo_stat_t;

    typedef struct packed {
        logic [15:0] left_ppr;
        logic [15:0] right_ppr;
        logic [19:0] left_radius;
        logic [19:0] right_radius;
        logic [20:0] wheel_base;
    } ddo_cfg_t;

    function automatic logic [31:0] atan_val(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ddo_ctrl.sv =====
// Odometry sequencing state machine; uses ddo_pkg.
// Issues one op per cycle; stalls while output is full.
`default_nettype none
module ddo_ctrl #(
    parameter int PULSE_BITS   = 16,
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ddo_pkg::ddo_stat_t stat,
    output ddo_pkg::ddo_cmd_t       cmd
);
    import ddo_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP  = 5'd1;
    localparam logic [4:0] S_WMUL  = 5'd2;
    localparam logic [4:0] S_WDL   = 5'd3;
    localparam logic [4:0] S_WDIV  = 5'd4;
    localparam logic [4:0] S_WMH   = 5'd5;
    localparam logic [4:0] S_WML   = 5'd6;
    localparam logic [4:0] S_WFIN  = 5'd7;
    localparam logic [4:0] S_BASE  = 5'd8;
    localparam logic [4:0] S_TDL   = 5'd9;
    localparam logic [4:0] S_TDIV  = 5'd10;
    localparam logic [4:0] S_TFIN  = 5'd11;
    localparam logic [4:0] S_CLD   = 5'd12;
    localparam logic [4:0] S_CSTEP = 5'd13;
    localparam logic [4:0] S_CFIN  = 5'd14;
    localparam logic [4:0] S_SMH   = 5'd15;
    localparam logic [4:0] S_SML   = 5'd16;
    localparam logic [4:0] S_SFIN  = 5'd17;
    localparam logic [4:0] S_DMX   = 5'd18;
    localparam logic [4:0] S_DMY   = 5'd19;
    localparam logic [4:0] S_QLD   = 5'd20;
    localparam logic [4:0] S_QSTEP = 5'd21;
    localparam logic [4:0] S_OUT   = 5'd22;

    localparam logic [CNT_W-1:0] WDIV_LAST = CNT_W'(PULSE_BITS + 35);
    localparam logic [CNT_W-1:0] TDIV_LAST = CNT_W'(DIV_W - 1);
    localparam logic [CNT_W-1:0] COR_LAST  = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(31);

    logic [4:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        s_ready    = 1'b0;
        cmd.op     = OP_NONE;
        cmd.sel    = sel_reg;
        cmd.idx    = cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                sel_next = 1'b0;
                if (stat.action) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DMX;
                end else begin
                    state_next = S_WMUL;
                end
            end
            S_WMUL: begin
                cmd.op     = OP_W_MUL;
                state_next = S_WDL;
            end
            S_WDL: begin
                cmd.op     = OP_W_DIVLD;
                cnt_next   = '0;
                state_next = S_WDIV;
            end
            S_WDIV: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == WDIV_LAST) begin
                    state_next = S_WMH;
                end
            end
            S_WMH: begin
                cmd.op     = OP_W_MULHI;
                state_next = S_WML;
            end
            S_WML: begin
                cmd.op     = OP_W_MULLO;
                state_next = S_WFIN;
            end
            S_WFIN: begin
                cmd.op = OP_W_FIN;
                if (!sel_reg) begin
                    sel_next   = 1'b1;
                    state_next = S_WMUL;
                end else begin
                    state_next = S_BASE;
                end
            end
            S_BASE: begin
                cmd.op     = OP_BASE_MUL;
                state_next = S_TDL;
            end
            S_TDL: begin
                cmd.op     = OP_T_DIVLD;
                cnt_next   = '0;
                state_next = S_TDIV;
            end
            S_TDIV: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == TDIV_LAST) begin
                    state_next = S_TFIN;
                end
            end
            S_TFIN: begin
                cmd.op     = OP_T_FIN;
                state_next = S_CLD;
            end
            S_CLD: begin
                cmd.op     = OP_COR_LD;
                cnt_next   = '0;
                state_next = S_CSTEP;
            end
            S_CSTEP: begin
                cmd.op   = OP_COR_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == COR_LAST) begin
                    state_next = S_CFIN;
                end
            end
            S_CFIN: begin
                cmd.op     = OP_COR_FIN;
                sel_next   = 1'b0;
                state_next = S_SMH;
            end
            S_SMH: begin
                cmd.op     = OP_S_MULHI;
                state_next = S_SML;
            end
            S_SML: begin
                cmd.op     = OP_S_MULLO;
                state_next = S_SFIN;
            end
            S_SFIN: begin
                cmd.op = OP_S_FIN;
                if (!sel_reg) begin
                    sel_next   = 1'b1;
                    state_next = S_SMH;
                end else begin
                    state_next = S_DMX;
                end
            end
            S_DMX: begin
                cmd.op     = OP_D_MULX;
                state_next = S_DMY;
            end
            S_DMY: begin
                cmd.op     = OP_D_MULY;
                state_next = S_QLD;
            end
            S_QLD: begin
                cmd.op     = OP_SQ_LD;
                cnt_next   = '0;
                state_next = S_QSTEP;
            end
            S_QSTEP: begin
                cmd.op   = OP_SQ_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SQ_LAST) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_wdiv_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WDIV) |-> (cnt_reg <= WDIV_LAST))
        else $error("wheel division ran past its last step");
    a_cor_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CSTEP) |-> (cnt_reg <= COR_LAST))
        else $error("rotation steps ran past the configured count");
    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DISP))
        else $error("accepted item was not dispatched");
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && stat.out_free) |=> (state_reg == S_IDLE))
        else $error("result was not handed over when the output was free");

endmodule
`default_nettype wire

// ===== hw/rtl/ddo_dp.sv =====
// Datapath of the odometry block: shared multiplier, divider, rotation and root units.
// Executes one operation per cycle from ddo_ctrl; uses ddo_pkg.
`default_nettype none
module ddo_dp #(
    parameter int PULSE_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire ddo_pkg::ddo_cmd_t            cmd,
    output ddo_pkg::ddo_stat_t                stat,
    input  wire ddo_pkg::ddo_cfg_t            cfg,
    input  wire logic                         s_action,
    input  wire logic signed [PULSE_BITS-1:0] s_left_pulses,
    input  wire logic signed [PULSE_BITS-1:0] s_right_pulses,
    input  wire logic signed [31:0]           s_new_x,
    input  wire logic signed [31:0]           s_new_y,
    input  wire logic [31:0]                  s_new_heading,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [31:0]                m_pose_x,
    output logic signed [31:0]                m_pose_y,
    output logic [31:0]                       m_pose_heading,
    output logic [31:0]                       m_distance_from_origin
);
    import ddo_pkg::*;

    localparam int MAG_W   = PULSE_BITS + 20;
    localparam int W_ALIGN = DIV_W - MAG_W;

    logic                         act_reg;
    logic signed [PULSE_BITS-1:0] pl_reg, pr_reg;
    logic signed [31:0]           nx_reg, ny_reg;
    logic [31:0]                  nh_reg;
    logic signed [ACC_W-1:0]      accx_reg, accx_next, accy_reg, accy_next;
    logic [31:0]                  head_reg, head_next;
    logic [63:0]                  prod_reg, prod_next, tmp_reg, tmp_next;
    logic [DIV_W-1:0]             dvd_reg, dvd_next;
    logic [DEN_W-1:0]             rem_reg, rem_next, den_reg, den_next;
    logic [QUO_W-1:0]             quo_reg, quo_next;
    logic                         ovf_reg, ovf_next;
    logic signed [47:0]           tl_reg, tl_next, tr_reg, tr_next, step_reg, step_next;
    logic [47:0]                  dmag_reg, dmag_next;
    logic                         dneg_reg, dneg_next;
    logic signed [COR_W-1:0]      cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic signed [COR_W-1:0]      cos_reg, cos_next, sin_reg, sin_next;
    logic [63:0]                  sqv_reg, sqv_next, sqr_reg, sqr_next;
    logic                         mvalid_reg, mvalid_next;
    logic signed [31:0]           mx_reg, mx_next, my_reg, my_next;
    logic [31:0]                  mh_reg, mh_next, md_reg, md_next;

    logic signed [PULSE_BITS-1:0] p_w;
    logic [PULSE_BITS-1:0]        pmag;
    logic [19:0]                  rad_w;
    logic [15:0]                  ppr_w;
    logic [31:0]                  mul_a, mul_b;
    logic [53:0]                  rem_sh, rem_diff;
    logic                         ge;
    logic [61:0]                  tsum;
    logic [48:0]                  tsh;
    logic [47:0]                  tmag;
    logic signed [48:0]           s49, d49;
    logic [47:0]                  stepmag;
    logic signed [COR_W-1:0]      trig, xs, ys;
    logic [31:0]                  trigmag, axmag, aymag, q32, atan_i;
    logic signed [31:0]           px, py;
    logic [63:0]                  ssum, sbit, stry;
    logic [49:0]                  rmag;
    logic signed [50:0]           dlt, asum, acc_sel;
    logic [5:0]                   sshift;

    assign stat.action   = act_reg;
    assign stat.out_free = !mvalid_reg || m_ready;

    assign m_valid                = mvalid_reg;
    assign m_pose_x               = mx_reg;
    assign m_pose_y               = my_reg;
    assign m_pose_heading         = mh_reg;
    assign m_distance_from_origin = md_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accx_reg   <= '0;
            accy_reg   <= '0;
            head_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            accx_reg   <= accx_next;
            accy_reg   <= accy_next;
            head_reg   <= head_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_CAPTURE) begin
            act_reg <= s_action;
            pl_reg  <= s_left_pulses;
            pr_reg  <= s_right_pulses;
            nx_reg  <= s_new_x;
            ny_reg  <= s_new_y;
            nh_reg  <= s_new_heading;
        end
        prod_reg <= prod_next;
        tmp_reg  <= tmp_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
        ovf_reg  <= ovf_next;
        tl_reg   <= tl_next;
        tr_reg   <= tr_next;
        step_reg <= step_next;
        dmag_reg <= dmag_next;
        dneg_reg <= dneg_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
        sqv_reg  <= sqv_next;
        sqr_reg  <= sqr_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        mh_reg   <= mh_next;
        md_reg   <= md_next;
    end

    always_comb begin
        p_w     = cmd.sel ? pr_reg : pl_reg;
        pmag    = p_w[PULSE_BITS-1] ? (~p_w + 1'b1) : p_w;
        rad_w   = cmd.sel ? cfg.right_radius : cfg.left_radius;
        ppr_w   = cmd.sel ? cfg.right_ppr : cfg.left_ppr;
        stepmag = step_reg[47] ? 48'(-step_reg) : 48'(step_reg);
        trig    = cmd.sel ? sin_reg : cos_reg;
        trigmag = trig[COR_W-1] ? 32'(-trig) : 32'(trig);
        px      = accx_reg[47:16];
        py      = accy_reg[47:16];
        axmag   = px[31] ? 32'(-px) : 32'(px);
        aymag   = py[31] ? 32'(-py) : 32'(py);
        q32     = quo_reg[31:0];
        atan_i  = atan_val(cmd.idx[4:0]);

        case (cmd.op)
            OP_W_MUL: begin
                mul_a = 32'(pmag);
                mul_b = 32'(rad_w);
            end
            OP_W_MULHI: begin
                mul_a = 32'(quo_reg[44:16]);
                mul_b = TWO_PI_Q29;
            end
            OP_W_MULLO: begin
                mul_a = 32'(quo_reg[15:0]);
                mul_b = TWO_PI_Q29;
            end
            OP_BASE_MUL: begin
                mul_a = 32'(cfg.wheel_base);
                mul_b = TWO_PI_Q29;
            end
            OP_S_MULHI: begin
                mul_a = stepmag[47:16];
                mul_b = trigmag;
            end
            OP_S_MULLO: begin
                mul_a = 32'(stepmag[15:0]);
                mul_b = trigmag;
            end
            OP_D_MULX: begin
                mul_a = axmag;
                mul_b = axmag;
            end
            OP_D_MULY: begin
                mul_a = aymag;
                mul_b = aymag;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        rem_sh   = {rem_reg, dvd_reg[DIV_W-1]};
        rem_diff = rem_sh - {1'b0, den_reg};
        ge       = rem_sh >= {1'b0, den_reg};

        tsum = tmp_reg[61:0] + 62'(prod_reg >> 16);
        tsh  = tsum[61:13];
        tmag = (ovf_reg || quo_reg[45] || tsh > 49'(TRAVEL_MAX)) ? TRAVEL_MAX : tsh[47:0];

        s49 = 49'(tl_reg) + 49'(tr_reg);
        d49 = 49'(tr_reg) - 49'(tl_reg);

        xs = cx_reg >>> cmd.idx[4:0];
        ys = cy_reg >>> cmd.idx[4:0];

        ssum    = tmp_reg + (prod_reg >> 16);
        rmag    = ssum[63:14];
        dlt     = (step_reg[47] ^ trig[COR_W-1]) ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
        acc_sel = cmd.sel ? 51'(accy_reg) : 51'(accx_reg);
        asum    = acc_sel + dlt;

        sshift = 6'd62 - {cmd.idx[4:0], 1'b0};
        sbit   = 64'd1 << sshift;
        stry   = sqr_reg + sbit;

        accx_next   = accx_reg;
        accy_next   = accy_reg;
        head_next   = head_reg;
        prod_next   = prod_reg;
        tmp_next    = tmp_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        quo_next    = quo_reg;
        ovf_next    = ovf_reg;
        tl_next     = tl_reg;
        tr_next     = tr_reg;
        step_next   = step_reg;
        dmag_next   = dmag_reg;
        dneg_next   = dneg_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        cz_next     = cz_reg;
        cos_next    = cos_reg;
        sin_next    = sin_reg;
        sqv_next    = sqv_reg;
        sqr_next    = sqr_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        mh_next     = mh_reg;
        md_next     = md_reg;
        mvalid_next = mvalid_reg && !m_ready;

        case (cmd.op)
            OP_W_MUL, OP_W_MULHI, OP_BASE_MUL, OP_S_MULHI, OP_D_MULX: begin
                prod_next = mul_a * mul_b;
            end
            OP_W_MULLO, OP_S_MULLO, OP_D_MULY: begin
                tmp_next  = prod_reg;
                prod_next = mul_a * mul_b;
            end
            default: begin
            end
        endcase

        case (cmd.op)
            OP_LOAD: begin
                accx_next = {nx_reg, 16'd0};
                accy_next = {ny_reg, 16'd0};
                head_next = nh_reg;
            end
            OP_W_DIVLD: begin
                dvd_next = DIV_W'(prod_reg[MAG_W-1:0]) << W_ALIGN;
                den_next = DEN_W'(ppr_w);
                rem_next = '0;
                quo_next = '0;
                ovf_next = 1'b0;
            end
            OP_DIV_STEP: begin
                rem_next = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], ge};
                ovf_next = ovf_reg | quo_reg[QUO_W-1];
                dvd_next = dvd_reg << 1;
            end
            OP_W_FIN: begin
                if (ppr_w == 16'd0) begin
                    if (cmd.sel) tr_next = '0;
                    else         tl_next = '0;
                end else if (cmd.sel) begin
                    tr_next = p_w[PULSE_BITS-1] ? -$signed(tmag) : $signed(tmag);
                end else begin
                    tl_next = p_w[PULSE_BITS-1] ? -$signed(tmag) : $signed(tmag);
                end
            end
            OP_BASE_MUL: begin
                step_next = 48'((s49 + 49'(s49[48])) >>> 1);
                dneg_next = d49[48];
                dmag_next = d49[48] ? 48'(-d49) : 48'(d49);
            end
            OP_T_DIVLD: begin
                dvd_next = {dmag_reg, 45'd0};
                den_next = prod_reg[DEN_W-1:0];
                rem_next = '0;
                quo_next = '0;
                ovf_next = 1'b0;
            end
            OP_T_FIN: begin
                if (cfg.wheel_base != 21'd0) begin
                    head_next = dneg_reg ? (head_reg - q32) : (head_reg + q32);
                end
            end
            OP_COR_LD: begin
                cx_next = CORDIC_X0;
                cy_next = '0;
                cz_next = $signed({3'd0, head_reg[29:0]});
            end
            OP_COR_STEP: begin
                if (!cz_reg[COR_W-1]) begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - $signed({1'b0, atan_i});
                end else begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + $signed({1'b0, atan_i});
                end
            end
            OP_COR_FIN: begin
                case (head_reg[31:30])
                    2'd0: begin
                        cos_next = cx_reg;
                        sin_next = cy_reg;
                    end
                    2'd1: begin
                        cos_next = -cy_reg;
                        sin_next = cx_reg;
                    end
                    2'd2: begin
                        cos_next = -cx_reg;
                        sin_next = -cy_reg;
                    end
                    default: begin
                        cos_next = cy_reg;
                        sin_next = -cx_reg;
                    end
                endcase
            end
            OP_S_FIN: begin
                if (cmd.sel) begin
                    if (asum > 51'sh0_7FFF_FFFF_FFFF) accy_next = 48'sh7FFF_FFFF_FFFF;
                    else if (asum < -51'sh0_8000_0000_0000) accy_next = 48'sh8000_0000_0000;
                    else accy_next = asum[47:0];
                end else begin
                    if (asum > 51'sh0_7FFF_FFFF_FFFF) accx_next = 48'sh7FFF_FFFF_FFFF;
                    else if (asum < -51'sh0_8000_0000_0000) accx_next = 48'sh8000_0000_0000;
                    else accx_next = asum[47:0];
                end
            end
            OP_SQ_LD: begin
                sqv_next = tmp_reg + prod_reg;
                sqr_next = '0;
            end
            OP_SQ_STEP: begin
                if (sqv_reg >= stry) begin
                    sqv_next = sqv_reg - stry;
                    sqr_next = (sqr_reg >> 1) + sbit;
                end else begin
                    sqr_next = sqr_reg >> 1;
                end
            end
            OP_OUT: begin
                mx_next     = px;
                my_next     = py;
                mh_next     = head_reg;
                md_next     = sqr_reg[31:0];
                mvalid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_OUT) |-> (!mvalid_reg || m_ready))
        else $error("result overwritten before it was taken");
    a_root_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_OUT) |-> (sqr_reg[63:32] == 32'd0))
        else $error("root wider than the distance field");
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_DIV_STEP && den_reg != '0) |=> (rem_reg < den_reg))
        else $error("division remainder not below divisor");

endmodule
`default_nettype wire

// ===== hw/rtl/differential_drive_odometry.sv =====
// Top level of the differential drive odometry block: configuration registers,
// controller and datapath. Depends on ddo_pkg, ddo_ctrl and ddo_dp.
//
//  Channel   Direction  Handshake            Content
//  s_*       in         s_valid / s_ready    action, wheel pulses, pose to load
//  m_*       out        m_valid / m_ready    pose x, y, heading, distance
//  cfg_*     in         cfg_wr_en            register index and data
//
// An update item runs the one-bit-per-cycle divider once per wheel and once for
// the turn, then the rotation unit and the square root unit; a load item runs
// only the squaring and the square root unit.
// Reset clears the pose and the configuration to their defaults.
// A finished result waits in the output register; the next item is accepted meanwhile.
`default_nettype none
module differential_drive_odometry #(
    parameter int PULSE_BITS   = 16,
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [2:0]                   cfg_index,
    input  wire logic [20:0]                  cfg_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_action,
    input  wire logic signed [PULSE_BITS-1:0] s_left_pulses,
    input  wire logic signed [PULSE_BITS-1:0] s_right_pulses,
    input  wire logic signed [31:0]           s_new_x,
    input  wire logic signed [31:0]           s_new_y,
    input  wire logic [31:0]                  s_new_heading,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [31:0]                m_pose_x,
    output logic signed [31:0]                m_pose_y,
    output logic [31:0]                       m_pose_heading,
    output logic [31:0]                       m_distance_from_origin
);
    import ddo_pkg::*;

    ddo_cfg_t  cfg_reg;
    ddo_cmd_t  cmd;
    ddo_stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.left_ppr     <= 16'd360;
            cfg_reg.right_ppr    <= 16'd360;
            cfg_reg.left_radius  <= 20'd20000;
            cfg_reg.right_radius <= 20'd20000;
            cfg_reg.wheel_base   <= 21'd80000;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LEFT_PPR:     cfg_reg.left_ppr     <= cfg_data[15:0];
                REG_RIGHT_PPR:    cfg_reg.right_ppr    <= cfg_data[15:0];
                REG_LEFT_RADIUS:  cfg_reg.left_radius  <= cfg_data[19:0];
                REG_RIGHT_RADIUS: cfg_reg.right_radius <= cfg_data[19:0];
                REG_WHEEL_BASE:   cfg_reg.wheel_base   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    ddo_ctrl #(
        .PULSE_BITS   (PULSE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ddo_dp #(
        .PULSE_BITS (PULSE_BITS)
    ) u_dp (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cmd                    (cmd),
        .stat                   (stat),
        .cfg                    (cfg_reg),
        .s_action               (s_action),
        .s_left_pulses          (s_left_pulses),
        .s_right_pulses         (s_right_pulses),
        .s_new_x                (s_new_x),
        .s_new_y                (s_new_y),
        .s_new_heading          (s_new_heading),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_pose_x               (m_pose_x),
        .m_pose_y               (m_pose_y),
        .m_pose_heading         (m_pose_heading),
        .m_distance_from_origin (m_distance_from_origin)
    );

endmodule
`default_nettype wire
